@@ design/vvg_pkg.sv @@
// Package for the voice volume gain chain: payload and config structs,
// sequencer state and gain-step enums, register map and arithmetic constants.
// No dependencies.
package vvg_pkg;

    // One volume update for one synthesizer voice
    typedef struct packed {
        logic [3:0]         voice;
        logic [7:0]         note_vel;
        logic signed [15:0] marker_level;
        logic signed [15:0] nested_marker_level;
        logic [15:0]        channel_volume;
        logic [15:0]        envelope_level;
        logic [15:0]        sound_gain;
        logic [14:0]        sequence_number;
        logic [15:0]        ramp_ticks;
    } vvg_upd_t;

    // One volume and ramp command
    typedef struct packed {
        logic [3:0]  out_voice;
        logic [14:0] out_volume;
        logic [28:0] ramp_time;
    } vvg_cmd_t;

    // Configuration register contents
    typedef struct packed {
        logic [7:0]  master_gain;
        logic [7:0]  music_gain_a;
        logic [7:0]  music_gain_b;
        logic [7:0]  global_gain_c;
        logic [8:0]  user_music_volume;
        logic [63:0] match_ids;
        logic [31:0] match_gains;
    } vvg_cfg_t;

    // Last values sent to one voice
    typedef struct packed {
        logic [14:0] volume;
        logic [15:0] ticks;
    } vvg_last_t;

    // Register map, one 64-bit slot per register
    typedef enum logic [2:0] {
        REG_MASTER_GAIN       = 3'd0,
        REG_MUSIC_GAIN_A      = 3'd1,
        REG_MUSIC_GAIN_B      = 3'd2,
        REG_GLOBAL_GAIN_C     = 3'd3,
        REG_USER_MUSIC_VOLUME = 3'd4,
        REG_MATCH_IDS         = 3'd5,
        REG_MATCH_GAINS       = 3'd6
    } vvg_reg_t;

    localparam int unsigned APB_ADDR_W = 6;
    localparam int unsigned APB_DATA_W = 64;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_BASE,
        ST_GAIN,
        ST_CHECK,
        ST_RAMP,
        ST_DONE
    } vvg_state_t;

    // Gain steps applied in order by the shared multiplier
    typedef enum logic [2:0] {
        GS_ENV    = 3'd0,
        GS_SOUND  = 3'd1,
        GS_MASTER = 3'd2,
        GS_MUSA   = 3'd3,
        GS_MUSB   = 3'd4,
        GS_USER   = 3'd5,
        GS_GLOBAL = 3'd6,
        GS_MATCH  = 3'd7
    } vvg_gstep_t;

    localparam int unsigned MATCH_USED = 4;

    localparam logic signed [33:0] LEVEL_LIMIT  = 34'sh0080_0000;
    localparam logic [14:0]        BASE_MAX     = 15'h7FFF;
    localparam logic [14:0]        VOL_MAX      = 15'h7FFF;
    localparam logic [16:0]        TICK_TIME    = 17'd5000;
    localparam logic [8:0]         UMV_RESET    = 9'h100;
    localparam logic [63:0]        IDS_RESET    = 64'hFFFF_FFFF_FFFF_FFFF;

endpackage

@@ design/vvg_if.sv @@
// Stream interfaces for the volume update input and the command output.
// Depends on vvg_pkg for the payload structs.
interface vvg_upd_if;
    logic              valid;
    logic              ready;
    vvg_pkg::vvg_upd_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface vvg_cmd_if;
    logic              valid;
    logic              ready;
    vvg_pkg::vvg_cmd_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ design/vvg_cfg_regs.sv @@
// APB-style configuration registers of the gain chain.
// Depends on vvg_pkg for the register map and the config struct.
module vvg_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [vvg_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [vvg_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [vvg_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output vvg_pkg::vvg_cfg_t                  cfg
);

    vvg_pkg::vvg_cfg_t cfg_reg;
    vvg_pkg::vvg_reg_t reg_sel;
    logic              wr_en;

    assign reg_sel = vvg_pkg::vvg_reg_t'(paddr[5:3]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Write the selected register on the access beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.master_gain       <= '0;
            cfg_reg.music_gain_a      <= '0;
            cfg_reg.music_gain_b      <= '0;
            cfg_reg.global_gain_c     <= '0;
            cfg_reg.user_music_volume <= vvg_pkg::UMV_RESET;
            cfg_reg.match_ids         <= vvg_pkg::IDS_RESET;
            cfg_reg.match_gains       <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                vvg_pkg::REG_MASTER_GAIN:       cfg_reg.master_gain <= pwdata[7:0];
                vvg_pkg::REG_MUSIC_GAIN_A:      cfg_reg.music_gain_a <= pwdata[7:0];
                vvg_pkg::REG_MUSIC_GAIN_B:      cfg_reg.music_gain_b <= pwdata[7:0];
                vvg_pkg::REG_GLOBAL_GAIN_C:     cfg_reg.global_gain_c <= pwdata[7:0];
                vvg_pkg::REG_USER_MUSIC_VOLUME: cfg_reg.user_music_volume <= pwdata[8:0];
                vvg_pkg::REG_MATCH_IDS:         cfg_reg.match_ids <= pwdata;
                vvg_pkg::REG_MATCH_GAINS:       cfg_reg.match_gains <= pwdata[31:0];
                default:                        ;
            endcase
        end
    end

    // Return the selected register on reads
    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            vvg_pkg::REG_MASTER_GAIN:       prdata = 64'(cfg_reg.master_gain);
            vvg_pkg::REG_MUSIC_GAIN_A:      prdata = 64'(cfg_reg.music_gain_a);
            vvg_pkg::REG_MUSIC_GAIN_B:      prdata = 64'(cfg_reg.music_gain_b);
            vvg_pkg::REG_GLOBAL_GAIN_C:     prdata = 64'(cfg_reg.global_gain_c);
            vvg_pkg::REG_USER_MUSIC_VOLUME: prdata = 64'(cfg_reg.user_music_volume);
            vvg_pkg::REG_MATCH_IDS:         prdata = cfg_reg.match_ids;
            vvg_pkg::REG_MATCH_GAINS:       prdata = 64'(cfg_reg.match_gains);
            default:                        prdata = '0;
        endcase
    end

endmodule

@@ design/vvg_voice_store.sv @@
// Per-voice memory of the last volume and ramp ticks sent.
// Valid bits clear at reset; an entry never written reads as zero.
// Depends on vvg_pkg for the entry struct.
module vvg_voice_store #(
    parameter int unsigned VOICE_COUNT = 16,
    parameter int unsigned IDX_W       = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [IDX_W-1:0]   rd_idx,
    output vvg_pkg::vvg_last_t rd_data,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_idx,
    input  vvg_pkg::vvg_last_t wr_data
);

    vvg_pkg::vvg_last_t     mem [VOICE_COUNT];
    logic [VOICE_COUNT-1:0] valid_reg;
    vvg_pkg::vvg_last_t     rd_data_reg;
    logic                   rd_valid_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx];
    end

    // Track written entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ design/voice_volume_gain_chain_unit.sv @@
// Top level of the voice volume gain chain: sequencer, shared multiplier,
// output register. Depends on vvg_pkg, vvg_if, vvg_cfg_regs, vvg_voice_store.
//
//   port   kind     dir  beat contents
//   -----  -------  ---  -------------------------------------------
//   upd    stream   in   vvg_upd_t: one volume update for one voice
//   cmd    stream   out  vvg_cmd_t: volume and ramp command
//   p*     APB      in   7 config registers at 8*i, 64-bit data
//
// After its beat an update holds the sequencer, which takes no new beat until
// it is back in idle; the update passes through one level multiply, a clamp,
// eight gain steps, the check and, for a command, the ramp multiply and the
// hand-off; all products use one 33x17 multiplier.
// rst_n clears the sequencer and the voice valid bits and resets the config registers.
// A finished command waits in the output register; a stalled cmd holds the
// sequencer in its last state only once the register is still full.
module voice_volume_gain_chain_unit #(
    parameter int unsigned VOICE_COUNT = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    vvg_upd_if.sink                        upd,
    vvg_cmd_if.source                      cmd,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vvg_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [vvg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [vvg_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int unsigned VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    vvg_pkg::vvg_cfg_t   cfg;
    vvg_pkg::vvg_state_t state_reg, state_next;
    vvg_pkg::vvg_gstep_t step_reg, step_next;
    vvg_pkg::vvg_upd_t   item_reg;
    vvg_pkg::vvg_last_t  last_data;
    vvg_pkg::vvg_last_t  new_last;
    vvg_pkg::vvg_cmd_t   cmd_reg;

    logic signed [33:0] level_reg, level_next;
    logic [31:0]        vol_reg, vol_next;
    logic [28:0]        ramp_reg, ramp_next;
    logic               cmd_valid_reg;

    logic               accept;
    logic               in_range;
    logic [6:0]         voice_ext;
    logic [VIDX_W-1:0]  voice_idx;
    logic signed [17:0] sum;
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] mul_p;
    logic [14:0]        base;
    logic [14:0]        vol_sat;
    logic               changed;
    logic               is_music;
    logic               match_hit;
    logic [7:0]         match_gain;
    logic [15:0]        gain;
    logic               gain_en;
    logic               st_wr;
    logic               load_out;
    logic               out_free;

    vvg_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign voice_ext = 7'(item_reg.voice);
    assign voice_idx = voice_ext[VIDX_W-1:0];
    assign new_last  = '{volume: vol_sat, ticks: item_reg.ramp_ticks};

    vvg_voice_store #(
        .VOICE_COUNT (VOICE_COUNT),
        .IDX_W       (VIDX_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (voice_idx),
        .rd_data (last_data),
        .wr_en   (st_wr),
        .wr_idx  (voice_idx),
        .wr_data (new_last)
    );

    // Handshake
    assign upd.ready = (state_reg == vvg_pkg::ST_IDLE);
    assign accept    = upd.valid && upd.ready;
    assign in_range  = (7'(upd.payload.voice) < 7'(VOICE_COUNT));
    assign out_free  = !cmd_valid_reg || cmd.ready;
    assign cmd.valid   = cmd_valid_reg;
    assign cmd.payload = cmd_reg;

    // Shared multiplier
    assign mul_p = mul_a * mul_b;

    // Intended level before the channel volume
    assign sum = $signed({10'd0, item_reg.note_vel})
               + 18'($signed(item_reg.marker_level))
               + 18'($signed(item_reg.nested_marker_level));

    // Clamp level into the 15-bit base
    always_comb
    begin
        priority if (level_reg >= vvg_pkg::LEVEL_LIMIT)
            base = vvg_pkg::BASE_MAX;
        else if (level_reg < 0)
            base = '0;
        else
            base = level_reg[22:8];
    end

    // Music sequences and first matching id
    assign is_music = (item_reg.sequence_number[14:8] == '0);

    always_comb
    begin
        match_hit  = 1'b0;
        match_gain = '0;
        for (int i = vvg_pkg::MATCH_USED - 1; i >= 0; i--)
        begin
            if ({1'b0, item_reg.sequence_number} == cfg.match_ids[16*i +: 16])
            begin
                match_hit  = 1'b1;
                match_gain = cfg.match_gains[8*i +: 8];
            end
        end
    end

    // Gain and bypass for the current step
    always_comb
    begin
        gain    = '0;
        gain_en = 1'b0;
        unique case (step_reg)
            vvg_pkg::GS_ENV:
            begin
                gain    = item_reg.envelope_level;
                gain_en = 1'b1;
            end
            vvg_pkg::GS_SOUND:
            begin
                gain    = item_reg.sound_gain;
                gain_en = (item_reg.sound_gain != '0);
            end
            vvg_pkg::GS_MASTER:
            begin
                gain    = 16'(cfg.master_gain);
                gain_en = (cfg.master_gain != '0);
            end
            vvg_pkg::GS_MUSA:
            begin
                gain    = 16'(cfg.music_gain_a);
                gain_en = is_music && (cfg.music_gain_a != '0);
            end
            vvg_pkg::GS_MUSB:
            begin
                gain    = 16'(cfg.music_gain_b);
                gain_en = is_music && (cfg.music_gain_b != '0);
            end
            vvg_pkg::GS_USER:
            begin
                gain    = 16'(cfg.user_music_volume);
                gain_en = is_music;
            end
            vvg_pkg::GS_GLOBAL:
            begin
                gain    = 16'(cfg.global_gain_c);
                gain_en = (cfg.global_gain_c != '0);
            end
            vvg_pkg::GS_MATCH:
            begin
                gain    = 16'(match_gain);
                gain_en = match_hit;
            end
            default:
            begin
                gain    = '0;
                gain_en = 1'b0;
            end
        endcase
    end

    // Saturate and compare with the voice's last command
    assign vol_sat = (vol_reg > 32'(vvg_pkg::VOL_MAX)) ? vvg_pkg::VOL_MAX : vol_reg[14:0];
    assign changed = (vol_sat != last_data.volume) || (item_reg.ramp_ticks != last_data.ticks);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vvg_pkg::ST_IDLE:
                if (accept && in_range)
                    state_next = vvg_pkg::ST_LEVEL;
            vvg_pkg::ST_LEVEL:
                state_next = vvg_pkg::ST_BASE;
            vvg_pkg::ST_BASE:
                state_next = vvg_pkg::ST_GAIN;
            vvg_pkg::ST_GAIN:
                if (step_reg == vvg_pkg::GS_MATCH)
                    state_next = vvg_pkg::ST_CHECK;
            vvg_pkg::ST_CHECK:
                state_next = changed ? vvg_pkg::ST_RAMP : vvg_pkg::ST_IDLE;
            vvg_pkg::ST_RAMP:
                state_next = vvg_pkg::ST_DONE;
            vvg_pkg::ST_DONE:
                if (out_free)
                    state_next = vvg_pkg::ST_IDLE;
            default:
                state_next = vvg_pkg::ST_IDLE;
        endcase
    end

    // Datapath steering per state
    always_comb
    begin
        level_next = level_reg;
        vol_next   = vol_reg;
        step_next  = step_reg;
        ramp_next  = ramp_reg;
        mul_a      = '0;
        mul_b      = '0;
        st_wr      = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            vvg_pkg::ST_IDLE:
            begin
            end
            vvg_pkg::ST_LEVEL:
            begin
                mul_a      = 33'(sum);
                mul_b      = $signed({1'b0, item_reg.channel_volume});
                level_next = mul_p[33:0];
            end
            vvg_pkg::ST_BASE:
            begin
                vol_next  = 32'(base);
                step_next = vvg_pkg::GS_ENV;
            end
            vvg_pkg::ST_GAIN:
            begin
                mul_a = $signed({1'b0, vol_reg});
                mul_b = $signed({1'b0, gain});
                if (gain_en)
                    vol_next = mul_p[39:8];
                if (step_reg != vvg_pkg::GS_MATCH)
                    step_next = vvg_pkg::vvg_gstep_t'(step_reg + 3'd1);
            end
            vvg_pkg::ST_CHECK:
            begin
                st_wr    = changed;
                vol_next = 32'(vol_sat);
            end
            vvg_pkg::ST_RAMP:
            begin
                mul_a     = $signed({17'd0, item_reg.ramp_ticks});
                mul_b     = $signed(vvg_pkg::TICK_TIME);
                ramp_next = mul_p[28:0];
            end
            vvg_pkg::ST_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vvg_pkg::ST_IDLE;
            step_reg      <= vvg_pkg::GS_ENV;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (load_out)
                cmd_valid_reg <= 1'b1;
            else if (cmd.ready)
                cmd_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= upd.payload;
        level_reg <= level_next;
        vol_reg   <= vol_next;
        ramp_reg  <= ramp_next;
        if (load_out)
        begin
            cmd_reg.out_voice  <= item_reg.voice;
            cmd_reg.out_volume <= vol_reg[14:0];
            cmd_reg.ramp_time  <= ramp_reg;
        end
    end

endmodule
